// ===== src/bitmap_page_allocator_defines.svh =====
// Assertion macros used by the checker of the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bpa_pkg.sv =====
package bpa_pkg;

	localparam int COUNT_W = 6;
	localparam int INDEX_W = 15;
	localparam int WORD_W  = 64;
	localparam int BIT_W   = 6;
	localparam int PCNT_W  = 7;

	localparam logic [INDEX_W-1:0] FIRST_PAGE_RST = 15'd3;

	localparam logic STATUS_GRANT = 1'b0;
	localparam logic STATUS_FAIL  = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SCAN      = 6'b000010,
		ST_FILL_RD   = 6'b000100,
		ST_FILL_WAIT = 6'b001000,
		ST_FILL_EMIT = 6'b010000,
		ST_FAIL      = 6'b100000
	} bpa_state_t;

	// Population count as a balanced adder tree.
	function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_W-1:0] v);
		logic [1:0] l1 [32];
		logic [2:0] l2 [16];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		return {1'b0, l5[0]} + {1'b0, l5[1]};
	endfunction

	// Position of the lowest set bit; isolate it, then encode the one-hot word.
	function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] oh;
		logic [BIT_W-1:0]  idx;
		oh  = v & (~v + 64'd1);
		idx = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (oh[k]) idx = idx | BIT_W'(k);
		end
		return idx;
	endfunction

endpackage

// ===== src/bpa_map_mem.sv =====
module bpa_map_mem
	import bpa_pkg::*;
#(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata,
	output logic              busy
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_s1;
	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	// After reset every word is swept to zero, one word a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign wr_en   = clr_busy_q | we;
	assign wr_addr = clr_busy_q ? clr_addr_q : waddr;
	assign wr_data = clr_busy_q ? '0 : wdata;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;
	assign busy  = clr_busy_q;

endmodule

// ===== src/bitmap_page_allocator.sv =====
// First-fit allocator of pages over a used-page bitmap.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes first_page, the lowest
// page that may be handed out; it is always ready. The user must write it
// only while idle; the block itself does not enforce this. Input channel
// (in_valid/in_ready/page_count) takes one request at a time. Output channel
// (out_valid/out_ready/page_index/status/last) gives one item per granted
// page in ascending order, last set on the final one, or a single failure
// item (status 1, page_index 0) when the count is out of range or too few
// pages are free; a failed request leaves the bitmap unchanged.
// A request first streams the bitmap words from first_page upward through the
// memory read port, one word a cycle, counting free pages until enough are
// seen. It then revisits those words: each is read in ST_FILL_RD and
// ST_FILL_WAIT, its free pages are granted in ST_FILL_EMIT, and the word is
// written back. After reset the bitmap memory is cleared word by word, and
// in_ready stays low meanwhile. A stalled receiver holds the page being emitted
// in the output register and the grant sequence waits; no item is lost.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int TOTAL_PAGES = 32768,
	parameter int MAX_REQUEST = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COUNT_W-1:0] page_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [INDEX_W-1:0] page_index,
	output logic               status,
	output logic               last
);

	localparam int MAP_WORDS = (TOTAL_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WCW_RAW   = $clog2(MAP_WORDS + 1);
	localparam int WCW       = (WCW_RAW > INDEX_W - BIT_W) ? WCW_RAW : INDEX_W - BIT_W;
	localparam int TAIL      = TOTAL_PAGES % WORD_W;
	localparam logic [WORD_W-1:0] TAIL_MASK =
		(TAIL == 0) ? {WORD_W{1'b1}} : ((64'd1 << TAIL) - 64'd1);
	localparam logic [WCW-1:0] LAST_WORD = WCW'(MAP_WORDS - 1);
	localparam logic [WCW-1:0] NUM_WORDS = WCW'(MAP_WORDS);

	bpa_state_t          state_q;
	logic [INDEX_W-1:0]  first_page_q;
	logic [COUNT_W-1:0]  want_q;
	logic [COUNT_W-1:0]  acc_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [WCW-1:0]      rd_word_q;
	logic [WCW-1:0]      cur_word_q;
	logic [WCW-1:0]      word_s1;
	logic                vld_s1;
	logic [WORD_W-1:0]   work_q;

	logic                out_valid_q;
	logic [INDEX_W-1:0]  page_index_q;
	logic                status_q;
	logic                last_q;

	logic                mem_busy;
	logic                mem_we;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [WORD_W-1:0]   mem_rdata;

	logic [WCW-1:0]      start_word;
	logic [BIT_W-1:0]    start_bit;
	logic                in_fire;
	logic                count_bad;
	logic                scan_issue;
	logic [WORD_W-1:0]   scan_free;
	logic [PCNT_W:0]     scan_sum;
	logic                scan_enough;
	logic [WORD_W-1:0]   fill_free;
	logic [BIT_W-1:0]    fill_bit;
	logic                out_slot;
	logic                fill_take;

	assign start_word = WCW'(first_page_q[INDEX_W-1:BIT_W]);
	assign start_bit  = first_page_q[BIT_W-1:0];
	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE) && !mem_busy;
	assign in_fire    = in_valid && in_ready;
	assign count_bad  = (page_count == '0) || (32'(page_count) > MAX_REQUEST);
	assign out_slot   = !out_valid_q || out_ready;

	// Counting pass: free pages of the word that has just been read.
	assign scan_issue  = (state_q == ST_SCAN) && (rd_word_q < NUM_WORDS);
	assign scan_free   = ~mem_rdata
		& ((word_s1 == start_word) ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}})
		& ((word_s1 == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}});
	assign scan_sum    = {2'b00, acc_q} + {1'b0, popcount64(scan_free)};
	assign scan_enough = scan_sum >= {2'b00, want_q};

	// Grant pass: free pages left in the working copy of the current word.
	assign fill_free = ~work_q
		& ((cur_word_q == start_word) ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}})
		& ((cur_word_q == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}});
	assign fill_bit  = lowest_index(fill_free);
	assign fill_take = (rem_q != '0) && (fill_free != '0);

	assign mem_re    = scan_issue || (state_q == ST_FILL_RD);
	assign mem_raddr = (state_q == ST_SCAN) ? rd_word_q[AW-1:0] : cur_word_q[AW-1:0];
	assign mem_we    = (state_q == ST_FILL_EMIT) && !fill_take;

	bpa_map_mem #(
		.DEPTH(MAP_WORDS),
		.AW   (AW)
	) u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (cur_word_q[AW-1:0]),
		.wdata (work_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.busy  (mem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= FIRST_PAGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			first_page_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= scan_issue;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (count_bad || (start_word >= NUM_WORDS)) begin
							state_q <= ST_FAIL;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (vld_s1) begin
						if (scan_enough) begin
							state_q <= ST_FILL_RD;
						end else if (word_s1 == LAST_WORD) begin
							state_q <= ST_FAIL;
						end
					end
				end
				ST_FILL_RD:   state_q <= ST_FILL_WAIT;
				ST_FILL_WAIT: state_q <= ST_FILL_EMIT;
				ST_FILL_EMIT: begin
					if (!fill_take) begin
						state_q <= (rem_q == '0) ? ST_IDLE : ST_FILL_RD;
					end
				end
				ST_FAIL: begin
					if (out_slot) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the request in progress.
	always_ff @(posedge clk) begin
		word_s1 <= rd_word_q;
		case (state_q)
			ST_IDLE: begin
				want_q    <= page_count;
				acc_q     <= '0;
				rd_word_q <= start_word;
			end
			ST_SCAN: begin
				if (scan_issue) begin
					rd_word_q <= rd_word_q + 1'b1;
				end
				if (vld_s1) begin
					acc_q <= scan_sum[COUNT_W-1:0];
				end
				cur_word_q <= start_word;
				rem_q      <= want_q;
			end
			ST_FILL_WAIT: begin
				work_q <= mem_rdata;
			end
			ST_FILL_EMIT: begin
				if (fill_take) begin
					if (out_slot) begin
						work_q <= work_q | (64'd1 << fill_bit);
						rem_q  <= rem_q - 1'b1;
					end
				end else begin
					cur_word_q <= cur_word_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FILL_EMIT && fill_take && out_slot)
				|| (state_q == ST_FAIL && out_slot)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL_EMIT && fill_take && out_slot) begin
			page_index_q <= {cur_word_q[INDEX_W-BIT_W-1:0], fill_bit};
			status_q     <= STATUS_GRANT;
			last_q       <= (rem_q == COUNT_W'(1));
		end else if (state_q == ST_FAIL && out_slot) begin
			page_index_q <= '0;
			status_q     <= STATUS_FAIL;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign page_index = page_index_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

// ===== src/bpa_checker.sv =====
`include "bitmap_page_allocator_defines.svh"

module bpa_checker
	import bpa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [INDEX_W-1:0] page_index,
	input logic               status,
	input logic               last
);

	// A failure item closes its request and names no page.
	`BPA_ASSERT_SAME(a_fail_shape, clk, arst_n, out_valid && (status == STATUS_FAIL), last && (page_index == '0), "failure item is not last or carries a page")

	// While a request still has pages to deliver no new request is taken.
	`BPA_ASSERT_SAME(a_busy_mid_request, clk, arst_n, out_valid && !last, !in_ready, "new request taken before the previous one finished")

	// Taking a request always leaves the idle state.
	`BPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready, "still ready right after accepting a request")

	// A stalled output item holds its payload.
	`BPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(page_index) && $stable(status) && $stable(last), "output item changed while stalled")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import bpa_pkg::*;

	localparam int TOTAL_PAGES = 32768;
	localparam int MAX_REQUEST = 32;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 30;
	localparam int IDLE_GUARD  = 16;
	localparam int DRAIN_WAIT  = 64;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [INDEX_W-1:0] page;
		logic               status;
		logic               last;
	} grant_t;

	// Mirror of the used-page bitmap; works out the grants of each request.
	class page_book;
		bit                 page_used [TOTAL_PAGES];
		logic [INDEX_W-1:0] first_page;
		grant_t             due_grants [$];
		int                 mismatches;
		int                 requests;
		int                 granted;
		int                 refused;

		function new();
			first_page = FIRST_PAGE_RST;
			mismatches = 0;
			requests   = 0;
			granted    = 0;
			refused    = 0;
		endfunction

		function void refuse();
			grant_t g;
			g.page   = '0;
			g.status = STATUS_FAIL;
			g.last   = 1'b1;
			due_grants.push_back(g);
			refused++;
		endfunction

		function void claim_pages(input logic [COUNT_W-1:0] count);
			int     taken [$];
			int     p;
			grant_t g;
			requests++;
			if (count == 0 || count > MAX_REQUEST) begin
				refuse();
				return;
			end
			for (p = int'(first_page); p < TOTAL_PAGES && taken.size() < int'(count); p++) begin
				if (!page_used[p]) begin
					page_used[p] = 1'b1;
					taken.push_back(p);
				end
			end
			// Ran off the top of the pool: give back what this request took.
			if (taken.size() < int'(count)) begin
				foreach (taken[i]) page_used[taken[i]] = 1'b0;
				refuse();
				return;
			end
			foreach (taken[i]) begin
				g.page   = INDEX_W'(taken[i]);
				g.status = STATUS_GRANT;
				g.last   = (i == taken.size() - 1);
				due_grants.push_back(g);
			end
			granted += taken.size();
		endfunction

		task flag_mismatch(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task match_grant(input logic [INDEX_W-1:0] page, input logic st, input logic fin);
			grant_t due;
			if (due_grants.size() == 0) begin
				flag_mismatch($sformatf("unexpected item page %0d status %b last %b",
					page, st, fin));
				return;
			end
			due = due_grants.pop_front();
			if (page !== due.page)
				flag_mismatch($sformatf("page_index %0d, wanted %0d", page, due.page));
			if (st !== due.status)
				flag_mismatch($sformatf("status %b, wanted %b (page %0d)", st, due.status,
					due.page));
			if (fin !== due.last)
				flag_mismatch($sformatf("last %b, wanted %b (page %0d)", fin, due.last,
					due.page));
		endtask
	endclass

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [INDEX_W-1:0] cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [COUNT_W-1:0] page_count = '0;
	logic               out_valid;
	logic               out_ready  = 1'b1;
	logic [INDEX_W-1:0] page_index;
	logic               status;
	logic               last;

	page_book           book = new();
	bit                 no_stalls = 1'b0;
	int                 stall_left = 0;
	int                 cycles = 0;
	int                 settings = 0;
	logic [INDEX_W-1:0] phase_base [PHASES];

	bitmap_page_allocator #(
		.TOTAL_PAGES(TOTAL_PAGES),
		.MAX_REQUEST(MAX_REQUEST)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.page_count(page_count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.page_index(page_index),
		.status    (status),
		.last      (last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.match_grant(page_index, status, last);
	end

	// Mostly short gaps, now and then a long one.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_stalls || r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Counts of zero and above the request limit are the odd cases; most are legal.
	function logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 8)
			return COUNT_W'($urandom_range(MAX_REQUEST + 1, 63));
		if (r < 25)
			return COUNT_W'(MAX_REQUEST);
		return COUNT_W'($urandom_range(1, MAX_REQUEST - 1));
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so back-to-back items need no drop in valid.
	task send_request(input logic [COUNT_W-1:0] count);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		page_count = count;
		do @(posedge clk); while (!in_ready);
		book.claim_pages(count);
		@(negedge clk);
	endtask

	task settle();
		in_valid = 1'b0;
		while (book.due_grants.size() != 0) @(negedge clk);
		repeat (IDLE_GUARD) @(negedge clk);
	endtask

	task write_first_page(input logic [INDEX_W-1:0] value);
		settle();
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		book.first_page = value;
		settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset value of first_page, then zero and over-limit counts.
		settings = 1;
		send_request(COUNT_W'(1));
		send_request(COUNT_W'(MAX_REQUEST));
		send_request(COUNT_W'(0));
		send_request(COUNT_W'(63));
		send_request(COUNT_W'(MAX_REQUEST + 1));

		// Top page of the pool: one grant, then nothing left.
		write_first_page('1);
		send_request(COUNT_W'(1));
		send_request(COUNT_W'(1));

		// Seven free pages at the top: asking for eight must roll back.
		write_first_page(INDEX_W'(TOTAL_PAGES - 8));
		send_request(COUNT_W'(8));
		send_request(COUNT_W'(7));
		send_request(COUNT_W'(1));

		write_first_page('0);
		send_request(COUNT_W'(3));
		send_request(COUNT_W'(MAX_REQUEST));

		// A used block in the middle of the scan leaves a split grant.
		write_first_page(INDEX_W'(100));
		send_request(COUNT_W'(5));
		write_first_page(INDEX_W'(98));
		send_request(COUNT_W'(10));
		write_first_page(INDEX_W'(16384));
		send_request(COUNT_W'(31));

		phase_base[0] = '0;
		phase_base[1] = INDEX_W'($urandom_range(1, 1500));
		phase_base[2] = INDEX_W'(TOTAL_PAGES - 1 - $urandom_range(0, 200));
		phase_base[3] = INDEX_W'($urandom_range(0, TOTAL_PAGES - 1));
		phase_base[4] = '1;

		foreach (phase_base[k]) begin
			write_first_page(phase_base[k]);
			no_stalls = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) send_request(pick_count());
		end

		settle();
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Ran %0d requests under %0d first-page settings, counts from 0 to 63.",
			book.requests, settings);
		$display("%0d pages granted first-fit; %0d requests refused, rollback included.",
			book.granted, book.refused);
		if (book.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/bpa_pkg.sv
src/bpa_map_mem.sv
src/bitmap_page_allocator.sv
src/bpa_checker.sv
tb/sv/tb.sv
